[sv/lru_keyed_cache_tags_core_defines.svh]
// assertion helpers for the lru tag store
`ifndef LRU_KEYED_CACHE_TAGS_CORE_DEFINES_SVH
`define LRU_KEYED_CACHE_TAGS_CORE_DEFINES_SVH

// same-cycle implication
`define LKCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkct assertion failed");

// next-cycle implication
`define LKCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkct assertion failed");

`endif

[sv/lkct_pkg.sv]
`default_nettype none

package lkct_pkg;

    localparam int WAYS_DEF   = 8;
    localparam int KEY_W      = 64;
    localparam int SLOT_W     = 3;
    localparam int IN_DATA_W  = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SLOT_W + KEY_W + 7) / 8) * 8;
    localparam int IN_USER_W  = 1;
    localparam int OUT_USER_W = 3;

endpackage

`default_nettype wire

[sv/lru_keyed_cache_tags_core.sv]
// an accepted input word is held in the input register, and its result word in the result register
// throughput: one word per cycle unless m_tready stalls; tag compare, free-slot and lru pick are one
// combinational pass between the input register and the result register
// lru order is kept as a pairwise age matrix updated on every hit or store
// reset clears the valid bits, the age matrix and both handshake stages;
// stored keys are not cleared and are only read while valid
`default_nettype none

`include "lru_keyed_cache_tags_core_defines.svh"

module lru_keyed_cache_tags_core
    import lkct_pkg::*;
#(
    parameter int WAYS = WAYS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // lookup_key
    input  wire logic [IN_USER_W-1:0]  s_tuser,   // build_ok
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // slot_index, evicted_key, zero pad
    output logic [OUT_USER_W-1:0]      m_tuser    // hit, stored, evicted
);

    localparam int IDX_W = $clog2(WAYS);

    // input stage
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [KEY_W-1:0]     in_key_reg;
    logic                 in_ok_reg;

    // tag store
    logic [WAYS-1:0]      valid_reg;
    logic [WAYS-1:0]      valid_next;
    logic [KEY_W-1:0]     key_reg [WAYS];
    logic [WAYS-1:0]      age_reg [WAYS];
    logic [WAYS-1:0]      age_next [WAYS];

    // result stage
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 hit_reg;
    logic                 stored_reg;
    logic                 evicted_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [KEY_W-1:0]     ev_key_reg;

    logic                 out_ready;
    logic                 fire;
    logic                 s_accept;

    logic [WAYS-1:0]      match;
    logic [WAYS-1:0]      lru_vec;
    logic                 hit_c;
    logic                 free_c;
    logic                 store_c;
    logic                 ev_c;
    logic                 touch_c;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     free_idx;
    logic [IDX_W-1:0]     lru_idx;
    logic [IDX_W-1:0]     way;
    logic [IDX_W+SLOT_W-1:0] way_ext;
    logic [SLOT_W-1:0]    slot_c;
    logic [KEY_W-1:0]     ev_key_c;

    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_key_reg <= s_tdata[KEY_W-1:0];
            in_ok_reg  <= s_tuser[0];
        end
    end

    // tag compare, free-slot and lru pick
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            match[i]   = valid_reg[i] && (key_reg[i] == in_key_reg);
            lru_vec[i] = ~|age_reg[i];
        end
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (lru_vec[i])
            begin
                lru_idx = IDX_W'(i);
            end
        end
    end

    assign hit_c   = |match;
    assign free_c  = ~&valid_reg;
    assign store_c = !hit_c && in_ok_reg;
    assign ev_c    = store_c && !free_c;
    assign touch_c = hit_c || store_c;
    assign way     = hit_c ? hit_idx : (free_c ? free_idx : lru_idx);
    assign way_ext = {{SLOT_W{1'b0}}, way};
    assign slot_c  = touch_c ? way_ext[SLOT_W-1:0] : '0;
    assign ev_key_c = ev_c ? key_reg[lru_idx] : '0;

    // touched way becomes newer than all others
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            age_next[i] = age_reg[i];
        end
        if (fire && touch_c)
        begin
            age_next[way] = '1;
            for (int i = 0; i < WAYS; i++)
            begin
                age_next[i][way] = 1'b0;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (fire && store_c)
        begin
            valid_next[way] = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            for (int i = 0; i < WAYS; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            for (int i = 0; i < WAYS; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && store_c)
        begin
            key_reg[way] <= in_key_reg;
        end
        if (fire)
        begin
            hit_reg     <= hit_c;
            stored_reg  <= store_c;
            evicted_reg <= ev_c;
            slot_reg    <= slot_c;
            ev_key_reg  <= ev_key_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - SLOT_W - KEY_W){1'b0}}, ev_key_reg, slot_reg};
    assign m_tuser  = {evicted_reg, stored_reg, hit_reg};

    `LKCT_ASSERT_NOW(a_hit_excl_store, m_tvalid, !(hit_reg && stored_reg))
    `LKCT_ASSERT_NOW(a_evict_needs_store, m_tvalid && evicted_reg, stored_reg)
    `LKCT_ASSERT_NOW(a_evict_only_full, fire && ev_c, &valid_reg)
    `LKCT_ASSERT_NEXT(a_valid_monotonic, 1'b1,
        $countones(valid_reg) >= $countones($past(valid_reg)))
    `LKCT_ASSERT_NOW(a_full_has_lru, fire && ev_c, $onehot(lru_vec))

endmodule

`default_nettype wire

[dv/lkct_result_monitor.sv]
`default_nettype none

module lkct_result_monitor
    import lkct_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [OUT_DATA_W-1:0] m_tdata,
    input  wire logic [OUT_USER_W-1:0] m_tuser,
    output int                         mismatch_count,
    output int                         outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIT_BIT     = 0;
    localparam int STORED_BIT  = 1;
    localparam int EVICTED_BIT = 2;

    typedef struct packed {
        logic              hit;
        logic              stored;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [KEY_W-1:0]  evicted_key;
    } tag_result_t;

    logic             way_valid [WAYS_DEF];
    logic [KEY_W-1:0] way_key   [WAYS_DEF];
    logic [63:0]      way_stamp [WAYS_DEF];
    logic [63:0]      use_tick;

    tag_result_t expected_q[$];
    int          mismatches = 0;

    function automatic tag_result_t lookup_and_update(input logic [KEY_W-1:0] key,
                                                      input logic build_ok);
        tag_result_t r;
        int          idx;
        r = '0;
        idx = -1;
        use_tick = use_tick + 64'd1;
        for (int i = 0; i < WAYS_DEF; i++)
        begin
            if (idx < 0 && way_valid[i] && way_key[i] == key)
                idx = i;
        end
        if (idx >= 0)
        begin
            way_stamp[idx] = use_tick;
            r.hit = 1'b1;
            r.slot = idx[SLOT_W-1:0];
        end
        else if (build_ok)
        begin
            for (int i = 0; i < WAYS_DEF; i++)
            begin
                if (idx < 0 && !way_valid[i])
                    idx = i;
            end
            if (idx < 0)
            begin
                // least recently used, lowest slot on a tie
                idx = 0;
                for (int i = 1; i < WAYS_DEF; i++)
                begin
                    if (way_stamp[i] < way_stamp[idx])
                        idx = i;
                end
                r.evicted = 1'b1;
                r.evicted_key = way_key[idx];
            end
            way_valid[idx] = 1'b1;
            way_key[idx] = key;
            way_stamp[idx] = use_tick;
            r.stored = 1'b1;
            r.slot = idx[SLOT_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatches++;
        $display("%0t mismatch %s: expected %h got %h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tag_result_t want;
        tag_result_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < WAYS_DEF; i++)
            begin
                way_valid[i] = 1'b0;
                way_key[i] = '0;
                way_stamp[i] = '0;
            end
            use_tick = '0;
            expected_q.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_q.push_back(lookup_and_update(s_tdata[KEY_W-1:0], s_tuser[0]));
            if (m_tvalid && m_tready)
            begin
                got.hit = m_tuser[HIT_BIT];
                got.stored = m_tuser[STORED_BIT];
                got.evicted = m_tuser[EVICTED_BIT];
                got.slot = m_tdata[SLOT_W-1:0];
                got.evicted_key = m_tdata[SLOT_W +: KEY_W];
                if (expected_q.size() == 0)
                    report_mismatch("unexpected word", '0, {32'd0, 29'd0, got.slot});
                else
                begin
                    want = expected_q.pop_front();
                    if (got.hit != want.hit)
                        report_mismatch("hit", 64'(want.hit), 64'(got.hit));
                    if (got.stored != want.stored)
                        report_mismatch("stored", 64'(want.stored), 64'(got.stored));
                    if (got.slot != want.slot)
                        report_mismatch("slot_index", 64'(want.slot), 64'(got.slot));
                    if (got.evicted != want.evicted)
                        report_mismatch("evicted", 64'(want.evicted), 64'(got.evicted));
                    if (got.evicted_key != want.evicted_key)
                        report_mismatch("evicted_key", want.evicted_key, got.evicted_key);
                end
            end
        end
        mismatch_count <= mismatches;
        outstanding <= expected_q.size();
    end

endmodule

`default_nettype wire

[dv/lru_keyed_cache_tags_core_tb.sv]
`default_nettype none

module lru_keyed_cache_tags_core_tb
    import lkct_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1550;
    localparam int POOL_SIZE    = 12;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // lookup_key
    logic [IN_USER_W-1:0]  s_tuser = '0;   // build_ok
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // slot_index, evicted_key, zero pad
    logic [OUT_USER_W-1:0] m_tuser;         // hit, stored, evicted

    int mismatch_count;
    int outstanding;
    int tx_idle_pct = 16;
    int rx_idle_pct = 59;
    int stall_cycles = 0;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    always #2 clk = ~clk;

    lru_keyed_cache_tags_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lkct_result_monitor monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL lru_keyed_cache_tags_core");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_word(input logic [KEY_W-1:0] key, input logic build_ok);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= key;
        s_tuser <= build_ok;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_pause();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int               r;
        int               k;
        logic [KEY_W-1:0] one_hot;
        r = $urandom_range(99);
        k = $urandom_range(KEY_W - 1);
        one_hot = 64'd1 << k;
        if (r < 70)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        else if (r < 90)
            return {$urandom, $urandom};
        else if (r < 93)
            return '0;
        else if (r < 96)
            return '1;
        else if (r < 98)
            return one_hot;
        else
            return ~one_hot;
    endfunction

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, then fill all ways, then lru eviction
        send_word(64'h0, 1'b0);
        send_word(64'h0, 1'b1);
        send_word(64'h0, 1'b0);
        send_word('1, 1'b1);
        send_word('1, 1'b0);
        send_word(64'h8000_0000_0000_0000, 1'b1);
        send_word(64'h0000_0000_0000_0001, 1'b1);
        send_word(64'h5555_5555_5555_5555, 1'b1);
        send_word(64'haaaa_aaaa_aaaa_aaaa, 1'b1);
        send_word(64'h0123_4567_89ab_cdef, 1'b1);
        send_word(64'hfedc_ba98_7654_3210, 1'b1);
        send_word(64'h0, 1'b1);
        send_word(64'h3c3c_3c3c_3c3c_3c3c, 1'b0);
        send_word(64'h7fff_ffff_ffff_ffff, 1'b1);
        send_word('1, 1'b1);
        send_word(64'h8000_0000_0000_0000, 1'b0);
        send_word(64'h0000_0000_0000_0001, 1'b1);
        send_word(64'h8000_0000_0000_0000, 1'b1);
        drain_pause();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 16;
                    rx_idle_pct = 59;
                end
                1:
                begin
                    tx_idle_pct = 59;
                    rx_idle_pct = 16;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    drain_pause();
                end
            endcase
            for (int n = 0; n < RANDOM_WORDS / 3; n++)
            begin
                // slowly rotate the hot keys so old entries age out
                if ($urandom_range(99) < 4)
                    key_pool[$urandom_range(POOL_SIZE - 1)] = {$urandom, $urandom};
                send_word(pick_key(), $urandom_range(99) < 80);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("PASS lru_keyed_cache_tags_core");
        else
            $display("FAIL lru_keyed_cache_tags_core");
        $finish;
    end

endmodule

`default_nettype wire
